FILE: rtl/utf16_group_to_utf8_transcoder_core_assert.svh
// Assertion macros for the UTF-16 group to UTF-8 transcoder.
// Included by the top level; no other dependencies.
`ifndef UTF16_GROUP_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH
`define UTF16_GROUP_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH

`define U16U8_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u16u8 implication check failed");

`define U16U8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u16u8 next-cycle check failed");

`endif

FILE: rtl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 group to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

  typedef enum logic [2:0] {
    PH_HDR_LO  = 3'd0,
    PH_HDR_HI  = 3'd1,
    PH_LEN_A   = 3'd2,
    PH_LEN_B   = 3'd3,
    PH_UNIT_LO = 3'd4,
    PH_UNIT_HI = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERRUN   = 2'd1,
    ERR_SURROGATE = 2'd2
  } err_t;

  localparam logic [7:0] LONG_LEN_BIT = 8'h80;
  localparam logic [16:0] HEADER_BYTES = 17'd2;

  // One queued command: up to three encoded bytes, then an optional closing result.
  typedef struct packed {
    logic [1:0]       nbytes;
    logic [2:0][7:0]  enc;
    logic             tail;
    logic             tail_valid;
    logic             tail_eos;
    logic             tail_eog;
    logic [15:0]      cnt;
    logic [16:0]      used;
    err_t             err;
  } cmd_t;

endpackage

FILE: rtl/utf16_group_to_utf8_transcoder_core.sv
// Top level of the UTF-16 string-group to UTF-8 transcoder.
// Depends on u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back and the assertion header.
`include "utf16_group_to_utf8_transcoder_core_assert.svh"

// The block takes one stream byte per cycle whenever its command queue has room; the
// front end parses headers, length prefixes and UTF-16 units one byte at a time.
// Each byte that yields output queues one command of one to four results, and the back
// end sends at most one result per cycle through its output register. A code unit (two
// input bytes) yields one result for an ASCII unit, two for a two-byte sequence and three
// for a three-byte sequence, plus one more result when the unit closes a string.
// After a group length overrun or a surrogate unit the error result is sent once and
// every later byte is accepted and dropped until reset.
module utf16_group_to_utf8_transcoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] out_byte, [23:8] string_count,
                                 // [40:24] bytes_consumed, [42:41] error_code, pad
  output logic [2:0]  m_tuser,   // [0] byte_valid, [1] end_of_string, [2] end_of_group
  output logic        m_tlast    // last
);
  import u16u8_pkg::*;

  logic push, pop, q_valid, q_full;
  cmd_t push_cmd, head;

  u16u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  u16u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  u16u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `U16U8_ASSERT_IMPLY(a_err_cmd_alone, clk, rst, push && (push_cmd.err != ERR_NONE), push_cmd.nbytes == 2'd0 && push_cmd.tail && !push_cmd.tail_valid)
  `U16U8_ASSERT_IMPLY(a_byte_no_err, clk, rst, m_tvalid && m_tuser[0], m_tdata[42:41] == ERR_NONE)
  `U16U8_ASSERT_IMPLY(a_eos_is_nul, clk, rst, m_tvalid && m_tuser[1], m_tuser[0] && m_tdata[7:0] == 8'd0 && m_tlast)
  `U16U8_ASSERT_NEXT(a_pop_no_push_full, clk, rst, q_full && !pop, q_full)

endmodule

FILE: rtl/u16u8_front.sv
// Front end: parses the group/string/unit byte stream and builds one command per byte
// that yields results. Depends on u16u8_pkg.
module u16u8_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] in_byte
  input  logic             q_full,
  output logic             push,
  output u16u8_pkg::cmd_t  push_cmd
);
  import u16u8_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] group_left, group_left_next;
  logic [15:0] declared_len, declared_len_next;
  logic [14:0] units_left, units_left_next;
  logic [7:0]  held_low, held_low_next;
  logic [6:0]  len_high, len_high_next;
  logic [15:0] strings_seen, strings_seen_next;
  logic        error_flag, error_flag_next;

  logic [15:0] gl_dec;
  logic [15:0] word;
  logic [14:0] ul_dec;
  logic [15:0] ss_inc;
  logic        start_str;
  logic [14:0] str_n;
  cmd_t        cmd;

  assign s_tready = !q_full;
  assign gl_dec   = group_left - 16'd1;
  assign word     = {s_tdata, held_low};
  assign ul_dec   = units_left - 15'd1;
  assign ss_inc   = strings_seen + 16'd1;

  always_comb begin
    phase_next        = phase;
    group_left_next   = group_left;
    declared_len_next = declared_len;
    units_left_next   = units_left;
    held_low_next     = held_low;
    len_high_next     = len_high;
    strings_seen_next = strings_seen;
    error_flag_next   = error_flag;
    start_str         = 1'b0;
    str_n             = '0;
    push              = 1'b0;
    cmd               = '0;
    if (s_tvalid && s_tready && !error_flag) begin
      unique case (phase)
        PH_HDR_LO: begin
          held_low_next = s_tdata;
          phase_next    = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          declared_len_next = word;
          group_left_next   = word;
          strings_seen_next = '0;
          if (word == 16'd0) begin
            push           = 1'b1;
            cmd.tail       = 1'b1;
            cmd.tail_eog   = 1'b1;
            cmd.used       = HEADER_BYTES;
            phase_next     = PH_HDR_LO;
          end else begin
            phase_next = PH_LEN_A;
          end
        end
        PH_LEN_A: begin
          group_left_next = gl_dec;
          if ((s_tdata & LONG_LEN_BIT) != 8'd0) begin
            if (gl_dec == 16'd0) begin
              error_flag_next = 1'b1;
              push            = 1'b1;
              cmd.tail        = 1'b1;
              cmd.err         = ERR_OVERRUN;
            end else begin
              len_high_next = s_tdata[6:0];
              phase_next    = PH_LEN_B;
            end
          end else begin
            start_str = 1'b1;
            str_n     = {8'd0, s_tdata[6:0]};
          end
        end
        PH_LEN_B: begin
          group_left_next = gl_dec;
          start_str       = 1'b1;
          str_n           = {len_high, s_tdata};
        end
        PH_UNIT_LO: begin
          group_left_next = gl_dec;
          held_low_next   = s_tdata;
          phase_next      = PH_UNIT_HI;
        end
        PH_UNIT_HI: begin
          group_left_next = gl_dec;
          push            = 1'b1;
          if (word[15:11] == 5'b11011) begin
            error_flag_next = 1'b1;
            cmd.tail        = 1'b1;
            cmd.err         = ERR_SURROGATE;
          end else begin
            if (word < 16'h0080) begin
              cmd.nbytes = 2'd1;
              cmd.enc[0] = word[7:0];
            end else if (word < 16'h0800) begin
              cmd.nbytes = 2'd2;
              cmd.enc[0] = {3'b110, word[10:6]};
              cmd.enc[1] = {2'b10, word[5:0]};
            end else begin
              cmd.nbytes = 2'd3;
              cmd.enc[0] = {4'b1110, word[15:12]};
              cmd.enc[1] = {2'b10, word[11:6]};
              cmd.enc[2] = {2'b10, word[5:0]};
            end
            if (ul_dec == 15'd0) begin
              start_str = 1'b1;
            end else begin
              units_left_next = ul_dec;
              phase_next      = PH_UNIT_LO;
            end
          end
        end
        default: begin
          phase_next = PH_HDR_LO;
        end
      endcase

      if (start_str) begin
        if ({str_n, 1'b0} > group_left_next) begin
          error_flag_next = 1'b1;
          push            = 1'b1;
          cmd.tail        = 1'b1;
          cmd.err         = ERR_OVERRUN;
        end else begin
          units_left_next = str_n;
          if (str_n != 15'd0) begin
            phase_next = PH_UNIT_LO;
          end else begin
            push           = 1'b1;
            cmd.tail       = 1'b1;
            cmd.tail_valid = 1'b1;
            cmd.tail_eos   = 1'b1;
            if (group_left_next == 16'd0) begin
              cmd.tail_eog      = 1'b1;
              cmd.cnt           = ss_inc;
              cmd.used          = {1'b0, declared_len} + HEADER_BYTES;
              strings_seen_next = '0;
              phase_next        = PH_HDR_LO;
            end else begin
              strings_seen_next = ss_inc;
              phase_next        = PH_LEN_A;
            end
          end
        end
      end
    end
  end

  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR_LO;
      group_left   <= '0;
      declared_len <= '0;
      units_left   <= '0;
      held_low     <= '0;
      len_high     <= '0;
      strings_seen <= '0;
      error_flag   <= 1'b0;
    end else begin
      phase        <= phase_next;
      group_left   <= group_left_next;
      declared_len <= declared_len_next;
      units_left   <= units_left_next;
      held_low     <= held_low_next;
      len_high     <= len_high_next;
      strings_seen <= strings_seen_next;
      error_flag   <= error_flag_next;
    end
  end

endmodule

FILE: rtl/u16u8_fifo.sv
// Command queue between the front end and the back end.
// Depends on u16u8_pkg.
module u16u8_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u16u8_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output u16u8_pkg::cmd_t  head,
  output logic             q_valid,
  output logic             q_full
);
  import u16u8_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign q_full  = count == CW'(DEPTH);
  assign q_valid = count != '0;
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/u16u8_back.sv
// Back end: expands queued commands into result transfers, one per cycle unless m_tready
// holds the output, through an output register. Depends on u16u8_pkg.
module u16u8_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  u16u8_pkg::cmd_t  head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata,  // [7:0] out_byte, [23:8] string_count,
                                     // [40:24] bytes_consumed, [42:41] error_code, pad
  output logic [2:0]       m_tuser,  // [0] byte_valid, [1] end_of_string, [2] end_of_group
  output logic             m_tlast   // last
);
  import u16u8_pkg::*;

  logic [1:0]  idx;
  logic [2:0]  total;
  logic        is_last;
  logic        load;

  logic [7:0]  r_byte;
  logic        r_valid, r_eos, r_eog;
  logic [15:0] r_cnt;
  logic [16:0] r_used;
  err_t        r_err;

  logic [7:0]  out_byte;
  logic        byte_valid, end_of_string, end_of_group, last;
  logic [15:0] string_count;
  logic [16:0] bytes_consumed;
  err_t        error_code;

  assign total   = {1'b0, head.nbytes} + {2'b00, head.tail};
  assign is_last = ({1'b0, idx} + 3'd1) == total;
  assign load    = q_valid && (!m_tvalid || m_tready);
  assign pop     = load && is_last;

  always_comb begin
    if (idx < head.nbytes) begin
      r_byte  = head.enc[idx];
      r_valid = 1'b1;
      r_eos   = 1'b0;
      r_eog   = 1'b0;
      r_cnt   = '0;
      r_used  = '0;
      r_err   = ERR_NONE;
    end else begin
      r_byte  = '0;
      r_valid = head.tail_valid;
      r_eos   = head.tail_eos;
      r_eog   = head.tail_eog;
      r_cnt   = head.cnt;
      r_used  = head.used;
      r_err   = head.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= is_last ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= r_byte;
      byte_valid     <= r_valid;
      end_of_string  <= r_eos;
      end_of_group   <= r_eog;
      string_count   <= r_cnt;
      bytes_consumed <= r_used;
      error_code     <= r_err;
      last           <= is_last;
    end
  end

  assign m_tdata = {5'd0, error_code, bytes_consumed, string_count, out_byte};
  assign m_tuser = {end_of_group, end_of_string, byte_valid};
  assign m_tlast = last;

endmodule

FILE: verif/tb.sv
// Self-checking bench for utf16_group_to_utf8_transcoder_core: string groups in, UTF-8 out.
// A scoreboard class predicts every result from the accepted bytes; needs u16u8_pkg and the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u16u8_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        eos;
    logic        eog;
    logic [15:0] cnt;
    logic [16:0] used;
    err_t        err;
    logic        fin;
  } utf8_res_t;

  typedef enum int {
    FAULT_SHORT_PREFIX,
    FAULT_HUGE_COUNT,
    FAULT_SMALL_GROUP,
    FAULT_SURROGATE
  } fault_t;

  class utf8_scoreboard;
    utf8_res_t pending[$];
    int        mismatches;
    int        n_new;
    phase_t    phase;
    bit [15:0] group_left;
    bit [15:0] declared_len;
    bit [14:0] units_left;
    bit [7:0]  held_low;
    bit [6:0]  len_high;
    bit [15:0] strings_seen;
    bit        halted;

    function new();
      phase = PH_HDR_LO;
      group_left = 0;
      declared_len = 0;
      units_left = 0;
      held_low = 0;
      len_high = 0;
      strings_seen = 0;
      halted = 0;
      mismatches = 0;
      n_new = 0;
    endfunction

    function void push(bit [7:0] d, bit v, bit eos, bit eog, bit [15:0] cnt,
                       bit [16:0] used, err_t e);
      utf8_res_t r;
      r.data = d;
      r.valid = v;
      r.eos = eos;
      r.eog = eog;
      r.cnt = cnt;
      r.used = used;
      r.err = e;
      r.fin = 1'b0;
      pending.push_back(r);
      n_new++;
    endfunction

    function void emit_char(bit [7:0] d);
      push(d, 1'b1, 1'b0, 1'b0, 16'd0, 17'd0, ERR_NONE);
    endfunction

    function void fail(err_t e);
      halted = 1'b1;
      push(8'd0, 1'b0, 1'b0, 1'b0, 16'd0, 17'd0, e);
    endfunction

    function void open_string(bit [14:0] n);
      if (2 * int'(n) > int'(group_left)) begin
        fail(ERR_OVERRUN);
        return;
      end
      units_left = n;
      if (n != 0) begin
        phase = PH_UNIT_LO;
        return;
      end
      strings_seen++;
      if (group_left == 0) begin
        push(8'd0, 1'b1, 1'b1, 1'b1, strings_seen, {1'b0, declared_len} + HEADER_BYTES,
             ERR_NONE);
        strings_seen = 0;
        phase = PH_HDR_LO;
      end else begin
        push(8'd0, 1'b1, 1'b1, 1'b0, 16'd0, 17'd0, ERR_NONE);
        phase = PH_LEN_A;
      end
    endfunction

    function void note_byte(bit [7:0] b);
      bit [15:0] u;
      if (halted) return;
      n_new = 0;
      case (phase)
        PH_HDR_LO: begin
          held_low = b;
          phase = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          declared_len = {b, held_low};
          group_left = declared_len;
          strings_seen = 0;
          if (group_left == 0) begin
            push(8'd0, 1'b0, 1'b0, 1'b1, 16'd0, HEADER_BYTES, ERR_NONE);
            phase = PH_HDR_LO;
          end else begin
            phase = PH_LEN_A;
          end
        end
        PH_LEN_A: begin
          group_left--;
          if ((b & LONG_LEN_BIT) != 0) begin
            if (group_left == 0) begin
              fail(ERR_OVERRUN);
            end else begin
              len_high = b[6:0];
              phase = PH_LEN_B;
            end
          end else begin
            open_string({8'd0, b[6:0]});
          end
        end
        PH_LEN_B: begin
          group_left--;
          open_string({len_high, b});
        end
        PH_UNIT_LO: begin
          group_left--;
          held_low = b;
          phase = PH_UNIT_HI;
        end
        default: begin
          u = {b, held_low};
          group_left--;
          if (u >= 16'hd800 && u <= 16'hdfff) begin
            fail(ERR_SURROGATE);
          end else begin
            if (u < 16'h0080) begin
              emit_char(u[7:0]);
            end else if (u < 16'h0800) begin
              emit_char({3'b110, u[10:6]});
              emit_char({2'b10, u[5:0]});
            end else begin
              emit_char({4'b1110, u[15:12]});
              emit_char({2'b10, u[11:6]});
              emit_char({2'b10, u[5:0]});
            end
            units_left--;
            if (units_left == 0) open_string(15'd0);
            else phase = PH_UNIT_LO;
          end
        end
      endcase
      if (n_new > 0) pending[pending.size() - 1].fin = 1'b1;
    endfunction

    function string show(utf8_res_t r);
      return $sformatf("byte=%02h v=%0b eos=%0b eog=%0b cnt=%0d used=%0d err=%0d last=%0b",
                       r.data, r.valid, r.eos, r.eog, r.cnt, r.used, r.err, r.fin);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("tb: mismatch: %s", what);
    endfunction

    function void check_result(logic [47:0] data, logic [2:0] user, logic fin);
      utf8_res_t got;
      utf8_res_t want;
      got.data = data[7:0];
      got.cnt = data[23:8];
      got.used = data[40:24];
      got.err = err_t'(data[42:41]);
      got.valid = user[0];
      got.eos = user[1];
      got.eog = user[2];
      got.fin = fin;
      if (pending.size() == 0) begin
        report({"unexpected ", show(got)});
      end else begin
        want = pending.pop_front();
        if (got !== want) report({"expected ", show(want), " got ", show(got)});
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  utf8_scoreboard sb = new();
  logic [7:0]     group_body[$];
  bit             quiet = 1'b0;
  bit             hold_off_req = 1'b0;
  int             bytes_sent = 0;

  utf16_group_to_utf8_transcoder_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet || hold_off_req) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit [15:0] rand_unit();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0000, 16'h007f));
      1: return 16'($urandom_range(16'h0080, 16'h07ff));
      2: return 16'($urandom_range(16'h0800, 16'hd7ff));
      default: return 16'($urandom_range(16'he000, 16'hffff));
    endcase
  endfunction

  function automatic void add_prefix(bit [14:0] n, bit long_form);
    if (long_form) begin
      group_body.push_back({1'b1, n[14:8]});
      group_body.push_back(n[7:0]);
    end else begin
      group_body.push_back({1'b0, n[6:0]});
    end
  endfunction

  function automatic void add_unit(bit [15:0] u);
    group_body.push_back(u[7:0]);
    group_body.push_back(u[15:8]);
  endfunction

  function automatic void add_random_string();
    int r;
    int n;
    r = $urandom_range(0, 9);
    if (r == 0) n = 0;
    else if (r < 7) n = $urandom_range(1, 4);
    else if (r < 9) n = $urandom_range(5, 12);
    else n = $urandom_range(13, 40);
    add_prefix(15'(n), $urandom_range(0, 3) == 0);
    repeat (n) add_unit(rand_unit());
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_group();
    logic [7:0] bytes[$];
    int         len;
    bytes = group_body;
    group_body.delete();
    len = bytes.size();
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic send_fault();
    fault_t kind;
    kind = fault_t'($urandom_range(0, 3));
    case (kind)
      FAULT_SHORT_PREFIX: begin
        group_body.push_back(8'h80 | 8'($urandom_range(0, 127)));
        send_group();
      end
      FAULT_HUGE_COUNT: begin
        repeat (4) send_byte(8'hff);
      end
      FAULT_SMALL_GROUP: begin
        add_prefix(15'd3, 1'b0);
        add_unit(rand_unit());
        send_group();
      end
      default: begin
        add_prefix(15'd2, 1'b0);
        add_unit(rand_unit());
        add_unit(16'hd800 + 16'($urandom_range(0, 16'h07ff)));
        send_group();
      end
    endcase
    repeat (20) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          stall--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    bit hold_done;
    int n_strings;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_group();
    add_prefix(15'd0, 1'b0);
    send_group();
    add_prefix(15'd4, 1'b0);
    add_unit(16'h0000);
    add_unit(16'h007f);
    add_unit(16'h0080);
    add_unit(16'h07ff);
    add_prefix(15'd4, 1'b1);
    add_unit(16'h0800);
    add_unit(16'hd7ff);
    add_unit(16'he000);
    add_unit(16'hffff);
    send_group();

    while (bytes_sent < 320) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (!hold_done && bytes_sent >= 150) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      n_strings = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      repeat (n_strings) add_random_string();
      send_group();
    end
    quiet = 1'b0;
    send_fault();
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
